// File: hw/rtl/cawc_pkg.sv
// Shared types, constants and key helpers for the card access whitelist controller.
`timescale 1ns / 1ps
`default_nettype none

package cawc_pkg;

    // Table size default and fixed field widths
    localparam int TABLE_DEPTH_DEFAULT = 64;
    localparam int LEN_W       = 4;
    localparam int UID_LO_W    = 64;
    localparam int UID_HI_W    = 16;
    localparam int TICK_W      = 16;
    localparam int CFG_W       = 64;
    localparam int CFG_ADDR_W  = 3;
    localparam int OP_W        = 3;
    localparam int COUNT_OUT_W = 7;
    localparam int IN_DATA_W   = 88;
    localparam int OUT_DATA_W  = 16;

    localparam logic [LEN_W-1:0]  MAX_UID_LEN         = 4'd10;
    localparam logic [TICK_W-1:0] SHORT_TIMEOUT_RESET = 16'd2000;
    localparam logic [TICK_W-1:0] LONG_TIMEOUT_RESET  = 16'd5000;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ADD_LEN       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ADD_LOW       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ADD_HIGH      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REM_LEN       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_REM_LOW       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_REM_HIGH      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_TIMEOUT = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_TIMEOUT  = 3'd7;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_CARD   = 3'd1,
        OP_ADD    = 3'd2,
        OP_REMOVE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_OK     = 3'd1,
        MODE_BAD    = 3'd2,
        MODE_ADD    = 3'd3,
        MODE_REMOVE = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_CLEAR,
        ST_APPLY,
        ST_RESP
    } state_t;

    // Normalised card key: length clamped, unused bytes zeroed
    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [UID_HI_W-1:0] hi;
        logic [UID_LO_W-1:0] lo;
    } key_t;

    typedef struct packed {
        logic valid;
        key_t key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Status from the table scanner
    typedef struct packed {
        logic done;
        logic found;
        logic free_found;
    } scan_stat_t;

    // Result item, lowest field in the lowest bits
    typedef struct packed {
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   table_full;
        logic                   unknown_card;
        logic                   access_granted;
        logic                   mode_changed;
        logic                   card_known;
        logic [2:0]             mode;
    } result_t;

    // Clamp the length to ten bytes and zero every byte beyond it
    function automatic key_t make_key(input logic [LEN_W-1:0] len,
                                      input logic [UID_LO_W-1:0] lo,
                                      input logic [UID_HI_W-1:0] hi);
        key_t             k;
        logic [LEN_W-1:0] l;
        l = (len > MAX_UID_LEN) ? MAX_UID_LEN : len;
        k.len = l;
        for (int b = 0; b < 8; b++) begin
            k.lo[8*b +: 8] = (l > LEN_W'(b)) ? lo[8*b +: 8] : 8'h00;
        end
        k.hi[7:0]  = (l > 4'd8) ? hi[7:0]  : 8'h00;
        k.hi[15:8] = (l > 4'd9) ? hi[15:8] : 8'h00;
        return k;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cawc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module cawc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cawc_scan.sv
// Table scanner: reads every entry once, finds the matching key and the first free entry.
`timescale 1ns / 1ps
`default_nettype none

module cawc_scan
    import cawc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire key_t               key,
    output logic      [IDX_W-1:0]   rd_addr,
    input  wire logic [ENTRY_W-1:0] rd_data,
    output scan_stat_t              stat,
    output logic      [IDX_W-1:0]   found_idx,
    output logic      [IDX_W-1:0]   free_idx
);

    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             chk_valid_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    logic             chk_last_reg;
    logic             found_reg;
    logic             free_reg;
    logic [IDX_W-1:0] found_idx_reg;
    logic [IDX_W-1:0] free_idx_reg;

    entry_t rd_entry;
    logic   last_issue;
    logic   hit;
    logic   empty;

    assign rd_entry   = entry_t'(rd_data);
    assign last_issue = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign hit        = chk_valid_reg && rd_entry.valid && (rd_entry.key == key);
    assign empty      = chk_valid_reg && !rd_entry.valid;
    assign rd_addr    = idx_reg;

    // Issue one read a cycle, then compare the returned entry in the cycle after its read is issued
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            chk_last_reg  <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
        end else begin
            chk_valid_reg <= busy_reg;
            chk_last_reg  <= last_issue;
            if (start) begin
                busy_reg  <= 1'b1;
                idx_reg   <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end else begin
                if (busy_reg) begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (last_issue) begin
                        busy_reg <= 1'b0;
                    end
                end
                if (hit) begin
                    found_reg <= 1'b1;
                end
                if (empty) begin
                    free_reg <= 1'b1;
                end
            end
        end
    end

    // Hold the first matching and first free index
    always_ff @(posedge aclk) begin
        chk_idx_reg <= idx_reg;
        if (hit && !found_reg) begin
            found_idx_reg <= chk_idx_reg;
        end
        if (empty && !free_reg) begin
            free_idx_reg <= chk_idx_reg;
        end
    end

    assign stat.done       = chk_valid_reg && chk_last_reg;
    assign stat.found      = found_reg;
    assign stat.free_found = free_reg;
    assign found_idx       = found_idx_reg;
    assign free_idx        = free_idx_reg;

endmodule

`default_nettype wire

// File: hw/rtl/card_access_whitelist_controller.sv
// Flow: a tick, an unused op, or a card, add or remove with zero length goes straight to apply;
// a card, add or remove with a non-zero length first scans the table, one entry read a cycle;
// a clear first sweeps the table. One item is in flight at a time, and the next transfer is
// taken once the result enters the output stage. Reset is synchronous: control state
// clears, then a sweep marks every entry free, during which no input transfer is taken.
`timescale 1ns / 1ps
`default_nettype none

module card_access_whitelist_controller
    import cawc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // uid_len [3:0], uid_low [67:4], uid_high [83:68], zero fill [87:84]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // op [2:0]
    input  wire logic [OP_W-1:0]       s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // mode [2:0], card_known [3], mode_changed [4], access_granted [5],
    // unknown_card [6], table_full [7], entry_count [14:8], zero fill [15]
    output logic      [OUT_DATA_W-1:0] m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Configuration registers
    logic [LEN_W-1:0]    add_len_reg;
    logic [UID_LO_W-1:0] add_low_reg;
    logic [UID_HI_W-1:0] add_high_reg;
    logic [LEN_W-1:0]    rem_len_reg;
    logic [UID_LO_W-1:0] rem_low_reg;
    logic [UID_HI_W-1:0] rem_high_reg;
    logic [TICK_W-1:0]   short_to_reg;
    logic [TICK_W-1:0]   long_to_reg;

    // Control and item state
    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg;
    key_t              key_reg;
    logic [IDX_W-1:0]  clr_idx_reg;
    mode_t             mode_reg, mode_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    result_t           res_reg, res_next;
    logic              m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // Handshake and datapath signals
    key_t             in_key;
    logic             s_acc;
    logic             in_scan;
    logic             clr_last;
    logic             out_free;
    logic             out_load;
    logic             scan_start;
    scan_stat_t       scan_stat;
    logic [IDX_W-1:0] found_idx;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic             apply_we;
    logic [IDX_W-1:0] apply_addr;
    entry_t           apply_data;
    key_t             add_key;
    key_t             rem_key;
    logic             add_hit;
    logic             rem_hit;
    mode_t            card_mode;
    logic             known;
    logic             full;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    // Table storage and scanner
    cawc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cawc_scan #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (scan_start),
        .key       (key_reg),
        .rd_addr   (ram_raddr),
        .rd_data   (ram_rdata),
        .stat      (scan_stat),
        .found_idx (found_idx),
        .free_idx  (free_idx)
    );

    // Decode the incoming transfer
    assign in_key   = make_key(s_tdata[3:0], s_tdata[67:4], s_tdata[83:68]);
    assign s_acc    = s_tvalid && s_tready;
    assign in_scan  = ((s_tuser == OP_CARD) || (s_tuser == OP_ADD) || (s_tuser == OP_REMOVE))
                      && (in_key.len != '0);
    assign clr_last = (clr_idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign out_free = !m_tvalid_reg || m_tready;

    // Master card keys
    assign add_key = make_key(add_len_reg, add_low_reg, add_high_reg);
    assign rem_key = make_key(rem_len_reg, rem_low_reg, rem_high_reg);
    assign add_hit = (add_key.len != '0) && (key_reg == add_key);
    assign rem_hit = (rem_key.len != '0) && (key_reg == rem_key);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_acc) begin
                    if (in_scan) state_next = ST_SCAN;
                    else if (s_tuser == OP_CLEAR) state_next = ST_CLEAR;
                    else state_next = ST_APPLY;
                end
            end
            ST_SCAN: begin
                if (scan_stat.done) state_next = ST_APPLY;
            end
            ST_CLEAR: begin
                if (clr_last) state_next = ST_APPLY;
            end
            ST_APPLY: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs: handshake, scan start and table write port
    always_comb begin
        s_tready   = 1'b0;
        scan_start = 1'b0;
        out_load   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = clr_idx_reg;
        ram_wdata  = '0;
        unique case (state_reg)
            ST_INIT, ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_IDLE: begin
                s_tready   = 1'b1;
                scan_start = s_tvalid && in_scan;
            end
            ST_APPLY: begin
                ram_we    = apply_we;
                ram_waddr = apply_addr;
                ram_wdata = apply_data;
            end
            ST_RESP: begin
                out_load = out_free;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Mode of a card that neither enrols nor deletes
    always_comb begin
        priority if (add_hit) card_mode = MODE_ADD;
        else if (rem_hit) card_mode = MODE_REMOVE;
        else if (scan_stat.found) card_mode = MODE_OK;
        else card_mode = MODE_BAD;
    end

    // Apply the operation to mode, timer, count and table
    always_comb begin
        mode_next       = mode_reg;
        ticks_next      = ticks_reg;
        count_next      = count_reg;
        known           = 1'b0;
        full            = 1'b0;
        apply_we        = 1'b0;
        apply_addr      = found_idx;
        apply_data      = '0;
        unique case (op_reg)
            OP_TICK: begin
                if (mode_reg != MODE_IDLE) begin
                    if (ticks_reg <= TICK_W'(1)) begin
                        ticks_next = '0;
                        mode_next  = MODE_IDLE;
                    end else begin
                        ticks_next = ticks_reg - TICK_W'(1);
                    end
                end
            end
            OP_CARD: begin
                if (key_reg.len != '0) begin
                    if ((mode_reg == MODE_ADD) && !scan_stat.found) begin
                        // enrol the unknown card, or flag a full table
                        if (scan_stat.free_found) begin
                            apply_we         = 1'b1;
                            apply_addr       = free_idx;
                            apply_data.valid = 1'b1;
                            apply_data.key   = key_reg;
                            count_next       = count_reg + CNT_W'(1);
                            known            = 1'b1;
                        end else begin
                            full = 1'b1;
                        end
                        mode_next = MODE_IDLE;
                    end else if ((mode_reg == MODE_REMOVE) && scan_stat.found) begin
                        apply_we   = 1'b1;
                        count_next = (count_reg != '0) ? count_reg - CNT_W'(1) : count_reg;
                        mode_next  = MODE_IDLE;
                    end else begin
                        known = scan_stat.found;
                        if (card_mode != mode_reg) begin
                            mode_next  = card_mode;
                            ticks_next = ((card_mode == MODE_ADD) || (card_mode == MODE_REMOVE))
                                         ? long_to_reg : short_to_reg;
                        end
                    end
                end
            end
            OP_ADD: begin
                if (key_reg.len != '0) begin
                    if (scan_stat.found) begin
                        known = 1'b1;
                    end else if (scan_stat.free_found) begin
                        apply_we         = 1'b1;
                        apply_addr       = free_idx;
                        apply_data.valid = 1'b1;
                        apply_data.key   = key_reg;
                        count_next       = count_reg + CNT_W'(1);
                        known            = 1'b1;
                    end else begin
                        full = 1'b1;
                    end
                end
            end
            OP_REMOVE: begin
                if ((key_reg.len != '0) && scan_stat.found) begin
                    apply_we   = 1'b1;
                    count_next = (count_reg != '0) ? count_reg - CNT_W'(1) : count_reg;
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    // Form the result item
    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};
    always_comb begin
        res_next.mode           = mode_next;
        res_next.card_known     = known;
        res_next.mode_changed   = (mode_next != mode_reg);
        res_next.access_granted = (mode_next != mode_reg) && (mode_next == MODE_OK);
        res_next.unknown_card   = (mode_next != mode_reg) && (mode_next == MODE_BAD);
        res_next.table_full     = full;
        res_next.entry_count    = count_ext[COUNT_OUT_W-1:0];
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            add_len_reg  <= '0;
            add_low_reg  <= '0;
            add_high_reg <= '0;
            rem_len_reg  <= '0;
            rem_low_reg  <= '0;
            rem_high_reg <= '0;
            short_to_reg <= SHORT_TIMEOUT_RESET;
            long_to_reg  <= LONG_TIMEOUT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_ADD_LEN:       add_len_reg  <= cfg_wdata[LEN_W-1:0];
                CFG_ADD_LOW:       add_low_reg  <= cfg_wdata[UID_LO_W-1:0];
                CFG_ADD_HIGH:      add_high_reg <= cfg_wdata[UID_HI_W-1:0];
                CFG_REM_LEN:       rem_len_reg  <= cfg_wdata[LEN_W-1:0];
                CFG_REM_LOW:       rem_low_reg  <= cfg_wdata[UID_LO_W-1:0];
                CFG_REM_HIGH:      rem_high_reg <= cfg_wdata[UID_HI_W-1:0];
                CFG_SHORT_TIMEOUT: short_to_reg <= cfg_wdata[TICK_W-1:0];
                CFG_LONG_TIMEOUT:  long_to_reg  <= cfg_wdata[TICK_W-1:0];
                default:           add_len_reg  <= add_len_reg;
            endcase
        end
    end

    // Control state: sequencer, sweep counter, mode, timer, count, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            clr_idx_reg  <= '0;
            mode_reg     <= MODE_IDLE;
            ticks_reg    <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_INIT) || (state_reg == ST_CLEAR)) begin
                clr_idx_reg <= clr_last ? '0 : clr_idx_reg + IDX_W'(1);
            end
            if (state_reg == ST_APPLY) begin
                mode_reg  <= mode_next;
                ticks_reg <= ticks_next;
                count_reg <= count_next;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload: latch the item on transfer, hold the result, load the output stage
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg  <= s_tuser;
            key_reg <= in_key;
        end
        if (state_reg == ST_APPLY) begin
            res_reg <= res_next;
        end
        if (out_load) begin
            m_tdata_reg <= {1'b0, res_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // Count of valid entries never exceeds the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table size");

    // Table is written only by the sweep or when an operation is applied
    a_write_window: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ((state_reg == ST_INIT) || (state_reg == ST_CLEAR)
                    || (state_reg == ST_APPLY)))
        else $error("table write outside sweep or apply");

    // Scan completion is only seen while the sequencer waits for it
    a_scan_done: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_stat.done |-> (state_reg == ST_SCAN))
        else $error("scan finished outside scan state");

    // A scan starts only on an input transfer and leads into the scan state
    a_scan_start: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_start |=> (state_reg == ST_SCAN))
        else $error("scan start without entering scan state");
`endif

endmodule

`default_nettype wire
